// ----- sv/stream_command_recovery_fsm_top_assert.svh -----
// Assertion macros shared by the checker files of this block.
// Both macros expect signals named clock and reset in the scope of use.
`ifndef STREAM_COMMAND_RECOVERY_FSM_TOP_ASSERT_SVH
`define STREAM_COMMAND_RECOVERY_FSM_TOP_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define SCR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scr assertion failed");

// Next-cycle implication, checked only outside reset.
`define SCR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scr assertion failed");

`endif

// ----- sv/scr_pkg.sv -----
`timescale 1ns / 1ps

package scr_pkg;

   localparam int SEQ_W   = 32;
   localparam int DELAY_W = 16;
   localparam int CSR_W   = 16;

   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 72;

   localparam logic [DELAY_W-1:0] RETRY_DELAY_RESET = 16'd120;
   localparam logic [DELAY_W-1:0] STALL_LIMIT_RESET = 16'd90;

   typedef enum logic [1:0] {
      MODE_TICK     = 2'd0,
      MODE_START    = 2'd1,
      MODE_RESTART  = 2'd2,
      MODE_CAMPAIGN = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_STOP_REQ = 2'd1,
      PH_WAIT     = 2'd2,
      PH_BACKOFF  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_STOP  = 2'd1,
      KIND_START = 2'd2
   } kind_type;

   typedef enum logic {
      CSR_RETRY_DELAY = 1'b0,
      CSR_STALL_LIMIT = 1'b1
   } csr_index_type;

   localparam logic [1:0] ST_APPLIED  = 2'd1;
   localparam logic [1:0] ST_REJECTED = 2'd2;

   localparam logic [2:0] RS_STOPPED     = 3'd1;
   localparam logic [2:0] RS_BUSY        = 3'd2;
   localparam logic [2:0] RS_SEND_FAILED = 3'd3;
   localparam logic [2:0] RS_TIMEOUT     = 3'd4;

   typedef struct packed {
      mode_type          mode;
      logic              continuous;
      logic              campaign_owns;
      logic              cmd_pending;
      logic              peer_ready;
      logic              link_accepts;
      logic [SEQ_W-1:0]  reported_sequence;
      logic [1:0]        reported_status;
      logic [2:0]        reported_reason;
      logic              frame_valid;
      logic [SEQ_W-1:0]  line_count;
   } item_type;

   typedef struct packed {
      logic [DELAY_W-1:0] retry_delay_ticks;
      logic [DELAY_W-1:0] stall_line_limit;
   } cfg_type;

   // Busy, send failed and timeout are worth a retry; anything else is final.
   function automatic logic is_transient(input logic [2:0] reason);
      is_transient = (reason == RS_BUSY) || (reason == RS_SEND_FAILED) ||
                     (reason == RS_TIMEOUT);
   endfunction

endpackage

// ----- sv/scr_csr_regs.sv -----
`timescale 1ns / 1ps

module scr_csr_regs
   import scr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [CSR_W-1:0]  csr_wdata,
   output cfg_type           cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_delay_ticks <= RETRY_DELAY_RESET;
         cfg_ff.stall_line_limit  <= STALL_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_RETRY_DELAY: cfg_ff.retry_delay_ticks <= csr_wdata;
            CSR_STALL_LIMIT: cfg_ff.stall_line_limit  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/scr_in_reg.sv -----
`timescale 1ns / 1ps

module scr_in_reg
   import scr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic                   advance,
   output logic                   item_valid,
   output item_type               item
);

   logic     in_valid_ff;
   item_type item_ff;
   item_type item_in;

   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      item_in.mode              = mode_type'(req_tuser);
      item_in.continuous        = req_tdata[0];
      item_in.campaign_owns     = req_tdata[1];
      item_in.cmd_pending       = req_tdata[2];
      item_in.peer_ready        = req_tdata[3];
      item_in.link_accepts      = req_tdata[4];
      item_in.reported_sequence = req_tdata[36:5];
      item_in.reported_status   = req_tdata[38:37];
      item_in.reported_reason   = req_tdata[41:39];
      item_in.frame_valid       = req_tdata[42];
      item_in.line_count        = req_tdata[74:43];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = in_valid_ff;
   assign item       = item_ff;

endmodule

// ----- sv/scr_engine.sv -----
`timescale 1ns / 1ps

module scr_engine
   import scr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  item_type               item,
   input  cfg_type                cfg,
   output logic                   advance,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [1:0]             rsp_tuser
);

   logic [SEQ_W-1:0]   next_sequence_ff, next_sequence_in;
   logic [SEQ_W-1:0]   live_sequence_ff, live_sequence_in;
   logic [SEQ_W-1:0]   stop_sequence_ff, stop_sequence_in;
   logic [DELAY_W-1:0] delay_count_ff, delay_count_in;
   phase_type          phase_ff, phase_in;
   logic               start_held_ff, start_held_in;
   logic               progress_armed_ff, progress_armed_in;
   logic [SEQ_W-1:0]   progress_mark_ff, progress_mark_in;
   logic [SEQ_W-1:0]   stall_total_ff, stall_total_in;

   logic               rsp_valid_ff;
   kind_type           kind_ff, kind_in;
   logic [SEQ_W-1:0]   iseq_ff, iseq_in;

   logic [SEQ_W-1:0]   seq_inc;
   logic [SEQ_W-1:0]   seq_take;
   logic [SEQ_W-1:0]   line_gap;

   assign advance  = item_valid && (!rsp_valid_ff || rsp_tready);
   assign seq_inc  = next_sequence_ff + 32'd1;
   // Sequence zero means "no command", so the counter skips it on wrap.
   assign seq_take = (seq_inc == '0) ? 32'd1 : seq_inc;
   assign line_gap = item.line_count - progress_mark_ff;

   always_comb begin
      logic go;
      logic cur_live;
      next_sequence_in  = next_sequence_ff;
      live_sequence_in  = live_sequence_ff;
      stop_sequence_in  = stop_sequence_ff;
      delay_count_in    = delay_count_ff;
      phase_in          = phase_ff;
      start_held_in     = start_held_ff;
      progress_armed_in = progress_armed_ff;
      progress_mark_in  = progress_mark_ff;
      stall_total_in    = stall_total_ff;
      kind_in           = KIND_NONE;
      iseq_in           = '0;
      go                = 1'b1;
      cur_live          = 1'b0;

      unique case (item.mode)
         MODE_TICK: begin
            // Retry service.
            if (item.campaign_owns) begin
               live_sequence_in = '0;
               stop_sequence_in = '0;
               delay_count_in   = '0;
               phase_in         = PH_IDLE;
               start_held_in    = 1'b0;
            end else begin
               cur_live = (live_sequence_ff != '0) &&
                          (item.reported_sequence == live_sequence_ff);
               if (phase_ff == PH_IDLE && cur_live &&
                   item.reported_status == ST_REJECTED) begin
                  if (!is_transient(item.reported_reason)) begin
                     live_sequence_in = '0;
                     start_held_in    = 1'b0;
                     go               = 1'b0;
                  end else begin
                     phase_in       = PH_STOP_REQ;
                     delay_count_in = '0;
                  end
               end
               if (go) begin
                  unique case (phase_in)
                     PH_STOP_REQ: begin
                        if (!item.cmd_pending && item.peer_ready) begin
                           if (delay_count_in != '0) begin
                              delay_count_in = delay_count_in - 16'd1;
                           end else begin
                              next_sequence_in = seq_take;
                              if (item.link_accepts) begin
                                 kind_in          = KIND_STOP;
                                 iseq_in          = seq_take;
                                 stop_sequence_in = seq_take;
                                 phase_in         = PH_WAIT;
                              end else begin
                                 delay_count_in = cfg.retry_delay_ticks;
                              end
                           end
                        end
                     end
                     PH_WAIT: begin
                        if (item.reported_sequence == stop_sequence_ff) begin
                           if (item.reported_status == ST_APPLIED &&
                               item.reported_reason == RS_STOPPED) begin
                              delay_count_in = cfg.retry_delay_ticks;
                              phase_in       = PH_BACKOFF;
                           end else if (item.reported_status == ST_REJECTED) begin
                              if (is_transient(item.reported_reason)) begin
                                 delay_count_in = cfg.retry_delay_ticks;
                                 phase_in       = PH_STOP_REQ;
                              end else begin
                                 live_sequence_in = '0;
                                 stop_sequence_in = '0;
                                 delay_count_in   = '0;
                                 phase_in         = PH_IDLE;
                                 start_held_in    = 1'b0;
                              end
                           end
                        end
                     end
                     PH_BACKOFF: begin
                        if (delay_count_ff != '0) begin
                           delay_count_in = delay_count_ff - 16'd1;
                        end else if (!item.cmd_pending && item.peer_ready) begin
                           if (!start_held_ff) begin
                              live_sequence_in = '0;
                              stop_sequence_in = '0;
                              phase_in         = PH_IDLE;
                           end else begin
                              next_sequence_in = seq_take;
                              if (item.link_accepts) begin
                                 kind_in           = KIND_START;
                                 iseq_in           = seq_take;
                                 live_sequence_in  = seq_take;
                                 stop_sequence_in  = '0;
                                 delay_count_in    = '0;
                                 phase_in          = PH_IDLE;
                                 progress_armed_in = 1'b0;
                              end else begin
                                 delay_count_in = cfg.retry_delay_ticks;
                              end
                           end
                        end
                     end
                     PH_IDLE: ;
                     default: ;
                  endcase
               end
            end

            // Progress (stall) watch, on the state the retry service left.
            if (item.frame_valid) begin
               progress_mark_in  = item.line_count;
               progress_armed_in = 1'b1;
            end else if (item.campaign_owns || phase_in != PH_IDLE ||
                         !start_held_in || live_sequence_in == '0 ||
                         item.reported_sequence != live_sequence_in ||
                         item.reported_status != ST_APPLIED ||
                         item.cmd_pending || !item.peer_ready) begin
               progress_armed_in = 1'b0;
            end else if (!progress_armed_in) begin
               progress_mark_in  = item.line_count;
               progress_armed_in = 1'b1;
            end else if (line_gap >= {16'd0, cfg.stall_line_limit}) begin
               stall_total_in    = stall_total_ff + 32'd1;
               progress_armed_in = 1'b0;
               delay_count_in    = '0;
               phase_in          = PH_STOP_REQ;
            end
         end
         MODE_START: begin
            next_sequence_in = seq_take;
            if (item.link_accepts) begin
               kind_in          = KIND_START;
               iseq_in          = seq_take;
               start_held_in    = item.continuous;
               live_sequence_in = item.continuous ? seq_take : '0;
               stop_sequence_in = '0;
               delay_count_in   = '0;
               phase_in         = PH_IDLE;
            end
         end
         MODE_RESTART: begin
            if (!item.campaign_owns) begin
               start_held_in    = 1'b1;
               live_sequence_in = '0;
               stop_sequence_in = '0;
               delay_count_in   = '0;
               phase_in         = PH_STOP_REQ;
            end
         end
         MODE_CAMPAIGN: begin
            live_sequence_in = '0;
            stop_sequence_in = '0;
            delay_count_in   = '0;
            phase_in         = PH_IDLE;
            start_held_in    = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_sequence_ff  <= '0;
         live_sequence_ff  <= '0;
         stop_sequence_ff  <= '0;
         delay_count_ff    <= '0;
         phase_ff          <= PH_IDLE;
         start_held_ff     <= 1'b0;
         progress_armed_ff <= 1'b0;
         progress_mark_ff  <= '0;
         stall_total_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (advance) begin
            next_sequence_ff  <= next_sequence_in;
            live_sequence_ff  <= live_sequence_in;
            stop_sequence_ff  <= stop_sequence_in;
            delay_count_ff    <= delay_count_in;
            phase_ff          <= phase_in;
            start_held_ff     <= start_held_in;
            progress_armed_ff <= progress_armed_in;
            progress_mark_ff  <= progress_mark_in;
            stall_total_ff    <= stall_total_in;
            rsp_valid_ff      <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff <= kind_in;
         iseq_ff <= iseq_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {5'd0, start_held_ff, stall_total_ff, phase_ff, iseq_ff};

endmodule

// ----- sv/stream_command_recovery_fsm_top.sv -----
`timescale 1ns / 1ps
// Stream command recovery supervisor.
// Each request word carries one service item: a tick, a submitted start, a
// restart request or a campaign takeover (req_tuser), plus the telemetry
// and link status seen at that moment (req_tdata). Each request word yields
// exactly one response word: the command issued (rsp_tuser) with its
// sequence number, the recovery phase after the item, the stall recovery
// count and whether a saved continuous start is held (rsp_tdata).
// The csr_ port writes retry_delay_ticks (index 0) and stall_line_limit
// (index 1); write it only while no word is in flight.
// A word accepted into the input register is handled by a single pass of
// compares and increments that computes the next state; the response
// register loads the result once it is empty or being drained. One word
// is accepted every cycle while rsp_tready stays high.
// A response waiting on rsp_tready holds its register; the input register
// still takes one more word, after which req_tready drops until the
// response drains. Reset clears all supervisor state, restores the default
// register values (120 and 90) and empties both registers.
module stream_command_recovery_fsm_top
   import scr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [0] continuous, [1] campaign_owns, [2] cmd_pending, [3] peer_ready,
   // [4] link_accepts, [36:5] reported_sequence, [38:37] reported_status,
   // [41:39] reported_reason, [42] frame_valid, [74:43] line_count
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] mode
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] issued_sequence, [33:32] recovery_phase,
   // [65:34] stall_recoveries, [66] saved_start_valid
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [1:0] issue_kind
   output logic [1:0]             rsp_tuser,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [CSR_W-1:0]       csr_wdata
);

   cfg_type  cfg;
   item_type item;
   logic     item_valid;
   logic     advance;

   scr_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   scr_in_reg u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   scr_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .cfg        (cfg),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- sv/scr_checker.sv -----
`timescale 1ns / 1ps
`include "stream_command_recovery_fsm_top_assert.svh"

module scr_checker
   import scr_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [1:0]             rsp_tuser
);

   // A stalled response keeps its word.
   `SCR_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // The input only stalls behind a response that is itself stalled.
   `SCR_ASSERT_NOW(a_full_stall, !req_tready, rsp_tvalid && !rsp_tready)

   // No command means no sequence number; a command always has a nonzero one.
   `SCR_ASSERT_NOW(a_none_no_seq, rsp_tvalid && rsp_tuser == KIND_NONE, rsp_tdata[31:0] == 32'd0)
   `SCR_ASSERT_NOW(a_issue_has_seq, rsp_tvalid && rsp_tuser != KIND_NONE, rsp_tdata[31:0] != 32'd0)

   // A stop leaves the block waiting for telemetry; a start leaves it idle.
   `SCR_ASSERT_NOW(a_issue_phase, rsp_tvalid && rsp_tuser != KIND_NONE, (rsp_tuser == KIND_STOP && rsp_tdata[33:32] == PH_WAIT) || (rsp_tuser == KIND_START && rsp_tdata[33:32] == PH_IDLE))

endmodule

bind stream_command_recovery_fsm_top scr_checker u_scr_checker (.*);

// ----- sim/scr_recovery_checker.sv -----
`timescale 1ns / 1ps

module scr_recovery_checker
   import scr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [1:0]             rsp_tuser,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [CSR_W-1:0]       csr_wdata,
   output int                     mismatches,
   output int                     in_flight
);

   localparam logic [15:0] DEFAULT_RETRY = 16'd120;
   localparam logic [15:0] DEFAULT_STALL = 16'd90;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] seq;
      phase_type   phase;
      logic [31:0] stalls;
      logic        held;
   } reply_type;

   reply_type expected_replies[$];

   logic [15:0] retry_ticks;
   logic [15:0] stall_limit;
   logic [31:0] seq_counter;
   logic [31:0] live_seq;
   logic [31:0] stop_seq;
   logic [15:0] hold_ticks;
   phase_type   stage;
   logic        start_saved;
   logic        armed;
   logic [31:0] mark_line;
   logic [31:0] stall_count;

   // Sequence numbers are consumed even when the link refuses the command,
   // and zero is never handed out.
   function automatic logic [31:0] bump_sequence();
      seq_counter = seq_counter + 32'd1;
      if (seq_counter == 32'd0)
         seq_counter = 32'd1;
      return seq_counter;
   endfunction

   function automatic void drop_stream();
      live_seq    = '0;
      stop_seq    = '0;
      hold_ticks  = '0;
      stage       = PH_IDLE;
      start_saved = 1'b0;
   endfunction

   function automatic reply_type forecast_reply(input item_type w);
      reply_type   r;
      logic        current;
      logic        transient;
      logic        halted;
      logic [31:0] issued;
      r.kind = KIND_NONE;
      r.seq = '0;
      transient = (w.reported_reason == RS_BUSY) || (w.reported_reason == RS_SEND_FAILED) ||
                  (w.reported_reason == RS_TIMEOUT);
      case (w.mode)
         MODE_TICK: begin
            // Command retry part of the tick.
            current = (live_seq != '0) && (w.reported_sequence == live_seq);
            if (w.campaign_owns) begin
               drop_stream();
            end else begin
               halted = 1'b0;
               if (stage == PH_IDLE && current && w.reported_status == ST_REJECTED) begin
                  if (!transient) begin
                     live_seq = '0;
                     start_saved = 1'b0;
                     halted = 1'b1;
                  end else begin
                     stage = PH_STOP_REQ;
                     hold_ticks = '0;
                  end
               end
               if (!halted) begin
                  case (stage)
                     PH_STOP_REQ: begin
                        if (!w.cmd_pending && w.peer_ready) begin
                           if (hold_ticks != '0) begin
                              hold_ticks = hold_ticks - 16'd1;
                           end else begin
                              issued = bump_sequence();
                              if (w.link_accepts) begin
                                 r.kind = KIND_STOP;
                                 r.seq = issued;
                                 stop_seq = issued;
                                 stage = PH_WAIT;
                              end else begin
                                 hold_ticks = retry_ticks;
                              end
                           end
                        end
                     end
                     PH_WAIT: begin
                        if (w.reported_sequence == stop_seq) begin
                           if (w.reported_status == ST_APPLIED &&
                               w.reported_reason == RS_STOPPED) begin
                              hold_ticks = retry_ticks;
                              stage = PH_BACKOFF;
                           end else if (w.reported_status == ST_REJECTED) begin
                              if (transient) begin
                                 hold_ticks = retry_ticks;
                                 stage = PH_STOP_REQ;
                              end else begin
                                 drop_stream();
                              end
                           end
                        end
                     end
                     PH_BACKOFF: begin
                        if (hold_ticks != '0) begin
                           hold_ticks = hold_ticks - 16'd1;
                        end else if (!w.cmd_pending && w.peer_ready) begin
                           if (!start_saved) begin
                              live_seq = '0;
                              stop_seq = '0;
                              stage = PH_IDLE;
                           end else begin
                              issued = bump_sequence();
                              if (w.link_accepts) begin
                                 r.kind = KIND_START;
                                 r.seq = issued;
                                 live_seq = issued;
                                 stop_seq = '0;
                                 hold_ticks = '0;
                                 stage = PH_IDLE;
                                 armed = 1'b0;
                              end else begin
                                 hold_ticks = retry_ticks;
                              end
                           end
                        end
                     end
                     default: ;
                  endcase
               end
            end
            // Stall watch part of the tick, on the state left by the retry part.
            current = (live_seq != '0) && (w.reported_sequence == live_seq);
            if (w.frame_valid) begin
               mark_line = w.line_count;
               armed = 1'b1;
            end else if (w.campaign_owns || stage != PH_IDLE || !start_saved || !current ||
                         w.reported_status != ST_APPLIED || w.cmd_pending ||
                         !w.peer_ready) begin
               armed = 1'b0;
            end else if (!armed) begin
               mark_line = w.line_count;
               armed = 1'b1;
            end else if ((w.line_count - mark_line) >= {16'd0, stall_limit}) begin
               stall_count = stall_count + 32'd1;
               armed = 1'b0;
               hold_ticks = '0;
               stage = PH_STOP_REQ;
            end
         end
         MODE_START: begin
            issued = bump_sequence();
            if (w.link_accepts) begin
               r.kind = KIND_START;
               r.seq = issued;
               start_saved = w.continuous;
               live_seq = w.continuous ? issued : 32'd0;
               stop_seq = '0;
               hold_ticks = '0;
               stage = PH_IDLE;
            end
         end
         MODE_RESTART: begin
            if (!w.campaign_owns) begin
               start_saved = 1'b1;
               live_seq = '0;
               stop_seq = '0;
               hold_ticks = '0;
               stage = PH_STOP_REQ;
            end
         end
         default: drop_stream();
      endcase
      r.phase = stage;
      r.stalls = stall_count;
      r.held = start_saved;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: response %s is %0h, expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      item_type  word;
      reply_type got;
      reply_type want;
      if (reset) begin
         expected_replies.delete();
         retry_ticks = DEFAULT_RETRY;
         stall_limit = DEFAULT_STALL;
         seq_counter = '0;
         live_seq    = '0;
         stop_seq    = '0;
         hold_ticks  = '0;
         stage       = PH_IDLE;
         start_saved = 1'b0;
         armed       = 1'b0;
         mark_line   = '0;
         stall_count = '0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_RETRY_DELAY)
               retry_ticks = csr_wdata;
            else
               stall_limit = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind   = kind_type'(rsp_tuser);
            got.seq    = rsp_tdata[31:0];
            got.phase  = phase_type'(rsp_tdata[33:32]);
            got.stalls = rsp_tdata[65:34];
            got.held   = rsp_tdata[66];
            if (expected_replies.size() == 0) begin
               report_mismatch("word with nothing outstanding", rsp_tdata[31:0], '0);
            end else begin
               want = expected_replies.pop_front();
               if (got.kind !== want.kind)
                  report_mismatch("issue_kind", got.kind, want.kind);
               if (got.seq !== want.seq)
                  report_mismatch("issued_sequence", got.seq, want.seq);
               if (got.phase !== want.phase)
                  report_mismatch("recovery_phase", got.phase, want.phase);
               if (got.stalls !== want.stalls)
                  report_mismatch("stall_recoveries", got.stalls, want.stalls);
               if (got.held !== want.held)
                  report_mismatch("saved_start_valid", got.held, want.held);
            end
         end
         if (req_tvalid && req_tready) begin
            word.mode              = mode_type'(req_tuser);
            word.continuous        = req_tdata[0];
            word.campaign_owns     = req_tdata[1];
            word.cmd_pending       = req_tdata[2];
            word.peer_ready        = req_tdata[3];
            word.link_accepts      = req_tdata[4];
            word.reported_sequence = req_tdata[36:5];
            word.reported_status   = req_tdata[38:37];
            word.reported_reason   = req_tdata[41:39];
            word.frame_valid       = req_tdata[42];
            word.line_count        = req_tdata[74:43];
            expected_replies.push_back(forecast_reply(word));
         end
      end
      in_flight = expected_replies.size();
   end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import scr_pkg::*;

   // Generous bound on the whole run.
   localparam int CYCLE_LIMIT = 300000;

   // Telemetry codes without a name in the package.
   localparam logic [1:0] STATUS_NONE  = 2'd0;
   localparam logic [1:0] STATUS_OTHER = 2'd3;
   localparam logic [2:0] REASON_NONE  = 3'd0;
   localparam logic [2:0] REASON_OTHER = 3'd5;

   // Flag bits for building directed words by hand.
   localparam logic [4:0] F_CONT   = 5'b10000;
   localparam logic [4:0] F_CAMP   = 5'b01000;
   localparam logic [4:0] F_PEND   = 5'b00100;
   localparam logic [4:0] F_READY  = 5'b00010;
   localparam logic [4:0] F_ACCEPT = 5'b00001;
   localparam logic [4:0] F_GO     = F_READY | F_ACCEPT;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // [0] continuous, [1] campaign_owns, [2] cmd_pending, [3] peer_ready,
   // [4] link_accepts, [36:5] reported_sequence, [38:37] reported_status,
   // [41:39] reported_reason, [42] frame_valid, [74:43] line_count
   logic [REQ_TDATA_W-1:0] req_tdata;
   // [1:0] mode
   logic [1:0]             req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // [31:0] issued_sequence, [33:32] recovery_phase,
   // [65:34] stall_recoveries, [66] saved_start_valid
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // [1:0] issue_kind
   logic [1:0]             rsp_tuser;
   logic                   csr_we;
   logic                   csr_index;
   logic [CSR_W-1:0]       csr_wdata;

   int mismatches;
   int in_flight;
   int cycle_count = 0;

   // When calm is set, neither side inserts random idle gaps; the long receiver holds still occur.
   logic calm = 1'b0;

   // Sequence numbers of the most recent start and stop seen on the
   // response side. The stimulus echoes them back as telemetry so that
   // the recovery sequences can actually complete.
   logic [31:0] last_start = '0;
   logic [31:0] last_stop  = '0;
   logic [31:0] line_now   = '0;
   int          scene      = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   stream_command_recovery_fsm_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // The checker watches both channels and the register port, predicts
   // every response word and counts the mismatches.
   scr_recovery_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .in_flight  (in_flight)
   );

   // Track the issued sequence numbers for the telemetry echo.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_tuser == KIND_START)
            last_start <= rsp_tdata[31:0];
         else if (rsp_tuser == KIND_STOP)
            last_stop <= rsp_tdata[31:0];
      end
   end

   // Watchdog. A hung handshake or a lost response word ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // Response side. Unless calm is set, each word is preceded by a random
   // gap with rsp_tready low. Twice during the run the receiver holds off for
   // a long stretch, so that the block fills up and drops req_tready.
   initial begin
      int taken;
      int gap;
      taken = 0;
      rsp_tready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (taken == 250 || taken == 800) begin
            rsp_tready <= 1'b0;
            repeat (80) @(posedge clock);
         end
         gap = calm ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   function automatic item_type service_word(input mode_type mode, input logic [4:0] flags,
                                             input logic [31:0] seq, input logic [1:0] status,
                                             input logic [2:0] reason, input logic frame,
                                             input logic [31:0] line);
      item_type w;
      w.mode              = mode;
      w.continuous        = flags[4];
      w.campaign_owns     = flags[3];
      w.cmd_pending       = flags[2];
      w.peer_ready        = flags[1];
      w.link_accepts      = flags[0];
      w.reported_sequence = seq;
      w.reported_status   = status;
      w.reported_reason   = reason;
      w.frame_valid       = frame;
      w.line_count        = line;
      return w;
   endfunction

   // Offer one request word, after an optional idle gap, and return right
   // after the edge at which it was accepted. The valid stays high, so a
   // following word with no gap goes out back to back.
   task automatic put_word(input item_type w);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= w.mode;
      req_tdata  <= {5'd0, w.line_count, w.frame_valid, w.reported_reason,
                     w.reported_status, w.reported_sequence, w.link_accepts,
                     w.peer_ready, w.cmd_pending, w.campaign_owns, w.continuous};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering and wait until every predicted response has arrived.
   // The first edge guarantees the checker has counted the last word.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (in_flight == 0);
      @(posedge clock);
   endtask

   // Directed words go one at a time so that the echoed sequence numbers
   // are always those of the word just before.
   task automatic directed_word(input item_type w);
      put_word(w);
      drain();
   endtask

   // A random word. Telemetry follows a scene that persists over several
   // words, so that runs of healthy telemetry (needed for a stall), stop
   // confirmations and rejections occur in a row; the rest is noise.
   task automatic random_word(output item_type w);
      int pick;
      w = '0;
      pick = $urandom_range(0, 99);
      if (pick < 76)
         w.mode = MODE_TICK;
      else if (pick < 88)
         w.mode = MODE_START;
      else if (pick < 96)
         w.mode = MODE_RESTART;
      else
         w.mode = MODE_CAMPAIGN;
      w.continuous    = ($urandom_range(0, 4) != 0);
      w.campaign_owns = ($urandom_range(0, 29) == 0);
      w.cmd_pending   = ($urandom_range(0, 9) == 0);
      w.peer_ready    = ($urandom_range(0, 9) != 0);
      w.link_accepts  = ($urandom_range(0, 7) != 0);
      w.frame_valid   = ($urandom_range(0, 7) == 0);
      // The line counter mostly creeps forward and wraps; now and then it
      // jumps anywhere.
      if ($urandom_range(0, 49) == 0)
         line_now = $urandom();
      else
         line_now = line_now + $urandom_range(0, 40);
      w.line_count = line_now;
      if ($urandom_range(0, 5) == 0) begin
         pick = $urandom_range(0, 11);
         if (pick < 4)
            scene = 0;
         else if (pick < 5)
            scene = 1;
         else if (pick < 8)
            scene = 2;
         else if (pick < 9)
            scene = 3;
         else if (pick < 10)
            scene = 4;
         else
            scene = 5;
      end
      case (scene)
         0: begin
            // Healthy live stream.
            w.reported_sequence = last_start;
            w.reported_status   = ST_APPLIED;
            w.reported_reason   = REASON_NONE;
         end
         1: begin
            // Live start rejected, mostly for a transient reason.
            w.reported_sequence = last_start;
            w.reported_status   = ST_REJECTED;
            if ($urandom_range(0, 3) != 0)
               w.reported_reason = 3'($urandom_range(RS_BUSY, RS_TIMEOUT));
            else
               w.reported_reason = ($urandom_range(0, 1) != 0) ? REASON_OTHER : RS_STOPPED;
         end
         2: begin
            // The stop took effect.
            w.reported_sequence = last_stop;
            w.reported_status   = ST_APPLIED;
            w.reported_reason   = RS_STOPPED;
         end
         3: begin
            w.reported_sequence = last_stop;
            w.reported_status   = ST_REJECTED;
            w.reported_reason   = 3'($urandom_range(0, 5));
         end
         4: begin
            w.reported_sequence = ($urandom_range(0, 1) != 0) ? last_stop : last_start;
            w.reported_status   = 2'($urandom_range(0, 3));
            w.reported_reason   = 3'($urandom_range(0, 5));
         end
         default: begin
            w.reported_sequence = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom();
            w.reported_status   = 2'($urandom_range(0, 3));
            w.reported_reason   = 3'($urandom_range(0, 5));
         end
      endcase
   endtask

   // One random phase: drain, write both registers while the block is
   // idle, then stream the given number of words.
   task automatic run_phase(input logic [15:0] retry, input logic [15:0] limit,
                            input logic steady, input int count);
      item_type w;
      drain();
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_RETRY_DELAY;
      csr_wdata <= retry;
      @(posedge clock);
      csr_index <= CSR_STALL_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we <= 1'b0;
      calm = steady;
      repeat (count) begin
         random_word(w);
         put_word(w);
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= MODE_TICK;
      csr_we     <= 1'b0;
      csr_index  <= CSR_RETRY_DELAY;
      csr_wdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with the registers at their reset values
      // (retry delay 120, stall limit 90).
      directed_word(service_word(MODE_TICK, F_GO, '0, STATUS_NONE, REASON_NONE, 1'b0, '0));
      directed_word(service_word(MODE_START, F_CONT | F_GO, '0, STATUS_NONE, REASON_NONE,
                                 1'b0, 32'd900));
      // Arm the stall watch, stay one line short of the limit, then stall.
      directed_word(service_word(MODE_TICK, F_GO, last_start, ST_APPLIED, REASON_NONE,
                                 1'b0, 32'd1000));
      directed_word(service_word(MODE_TICK, F_GO, last_start, ST_APPLIED, REASON_NONE,
                                 1'b0, 32'd1089));
      directed_word(service_word(MODE_TICK, F_GO, last_start, ST_APPLIED, REASON_NONE,
                                 1'b0, 32'd1090));
      // The stop waits for a ready peer and a free command slot; then the
      // link refuses it, which uses up a sequence number.
      directed_word(service_word(MODE_TICK, F_ACCEPT, '0, STATUS_NONE, REASON_NONE, 1'b0, '0));
      directed_word(service_word(MODE_TICK, F_PEND | F_GO, '0, STATUS_NONE, REASON_NONE,
                                 1'b0, '0));
      directed_word(service_word(MODE_TICK, F_READY, '0, STATUS_NONE, REASON_NONE, 1'b0, '0));
      directed_word(service_word(MODE_CAMPAIGN, F_GO, '0, STATUS_NONE, REASON_NONE, 1'b0, '0));
      // A permanent rejection abandons the stream.
      directed_word(service_word(MODE_START, F_CONT | F_GO, '0, STATUS_NONE, REASON_NONE,
                                 1'b0, '0));
      directed_word(service_word(MODE_TICK, F_GO, last_start, ST_REJECTED, REASON_OTHER,
                                 1'b0, '0));
      // A transient rejection sends a stop at once; a transient rejection of
      // that stop goes back to stop required with the retry delay loaded.
      directed_word(service_word(MODE_START, F_CONT | F_GO, '0, STATUS_NONE, REASON_NONE,
                                 1'b0, '0));
      directed_word(service_word(MODE_TICK, F_GO, last_start, ST_REJECTED, RS_BUSY,
                                 1'b0, '0));
      directed_word(service_word(MODE_TICK, F_GO, last_stop, ST_REJECTED, RS_TIMEOUT,
                                 1'b0, '0));
      // A restart while a campaign owns the scheduler is ignored; without
      // one it restarts recovery with no delay.
      directed_word(service_word(MODE_RESTART, F_CAMP | F_GO, '0, STATUS_NONE, REASON_NONE,
                                 1'b0, '0));
      directed_word(service_word(MODE_RESTART, F_GO, '0, STATUS_NONE, REASON_NONE, 1'b0, '0));
      directed_word(service_word(MODE_TICK, F_GO, '0, STATUS_NONE, REASON_NONE, 1'b0, '0));
      // Stop confirmed: back off. A campaign tick then drops everything.
      directed_word(service_word(MODE_TICK, F_GO, last_stop, ST_APPLIED, RS_STOPPED,
                                 1'b0, '0));
      directed_word(service_word(MODE_TICK, F_CAMP | F_GO, '0, STATUS_NONE, REASON_NONE,
                                 1'b0, '0));
      // A one-shot start is not saved; a refused start still uses a number.
      // The start path ignores campaign ownership.
      directed_word(service_word(MODE_START, F_CAMP | F_GO, '0, STATUS_NONE, REASON_NONE,
                                 1'b0, '0));
      directed_word(service_word(MODE_START, F_CONT | F_READY, '0, STATUS_NONE, REASON_NONE,
                                 1'b0, '0));
      directed_word(service_word(MODE_TICK, F_GO, 32'hFFFF_FFFF, STATUS_OTHER, REASON_OTHER,
                                 1'b1, 32'hFFFF_FFFF));
      // Send failure as a transient reason, then a stop rejected for a
      // permanent reason, which drops the stream.
      directed_word(service_word(MODE_START, F_CONT | F_GO, '0, STATUS_NONE, REASON_NONE,
                                 1'b0, '0));
      directed_word(service_word(MODE_TICK, F_GO, last_start, ST_REJECTED, RS_SEND_FAILED,
                                 1'b0, '0));
      directed_word(service_word(MODE_TICK, F_GO, last_stop, ST_REJECTED, RS_STOPPED,
                                 1'b0, '0));

      // Random part over several register settings, extremes included.
      // A zero stall limit declares a stall on the first tick after arming.
      run_phase(16'd0,      16'd0,      1'b0, 200);
      run_phase(16'd3,      16'd1,      1'b1, 200);
      run_phase(16'hFFFF,   16'hFFFF,   1'b0, 150);
      run_phase(16'd1,      16'd60,     1'b0, 240);
      run_phase(16'd0,      16'hFFFF,   1'b1, 160);
      run_phase(16'hFFFF,   16'd1,      1'b0, 160);
      run_phase(16'd2,      16'd25,     1'b0, 240);

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
